// ===== hw/rtl/lpt_pkg.sv =====
`default_nettype none

package lpt_pkg;

  localparam int unsigned LINE_BYTES_DEF = 4096;
  localparam int unsigned PAIR_SLOTS_DEF = 8;

  localparam int unsigned KIND_W       = 3;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned SPAN_START_W = 12;
  localparam int unsigned SPAN_LEN_W   = 13;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned CFG_W        = 4;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CNT_W-1:0] CFG_RESET_VAL = 4'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TAGS,
    CFG_MAX_FIELDS
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEAS,
    KIND_TAG_KEY,
    KIND_TAG_VAL,
    KIND_FIELD_KEY,
    KIND_FIELD_VAL,
    KIND_STAMP,
    KIND_STATUS
  } tok_kind_e;

  typedef enum logic [2:0] {
    PH_MEAS,
    PH_TAGK,
    PH_TAGV,
    PH_FKEY,
    PH_FVAL,
    PH_STAMP,
    PH_DRAIN
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]       token_kind;
    logic [IDX_W-1:0]        pair_index;
    logic [SPAN_START_W-1:0] span_start;
    logic [SPAN_LEN_W-1:0]   span_length;
    logic                    parse_ok;
    logic [CNT_W-1:0]        tag_total;
    logic [CNT_W-1:0]        field_total;
    logic                    last_result;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpt_core.sv =====
`default_nettype none

module lpt_core #(
  parameter int unsigned LINE_BYTES = lpt_pkg::LINE_BYTES_DEF,
  parameter int unsigned PAIR_SLOTS = lpt_pkg::PAIR_SLOTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire lpt_pkg::in_t                item_i,
  input  wire logic [lpt_pkg::CNT_W-1:0]   max_tags_i,
  input  wire logic [lpt_pkg::CNT_W-1:0]   max_fields_i,
  output lpt_pkg::step_t                   step_o
);

  localparam int unsigned PW   = $clog2(LINE_BYTES + 1);
  localparam int unsigned CW   = lpt_pkg::CNT_W;
  localparam int unsigned IW   = lpt_pkg::IDX_W;
  localparam int unsigned SSW  = lpt_pkg::SPAN_START_W;
  localparam int unsigned SLW  = lpt_pkg::SPAN_LEN_W;
  localparam logic [PW-1:0] LineMax = PW'(LINE_BYTES);
  localparam logic [CW-1:0] SlotCap = (PAIR_SLOTS < 15) ? CW'(PAIR_SLOTS) : CW'(15);

  function automatic lpt_pkg::res_t mk_res(
    lpt_pkg::tok_kind_e kind,
    logic [CW-1:0]      idx,
    logic [PW-1:0]      start,
    logic [PW-1:0]      len,
    logic               ok,
    logic [CW-1:0]      tags,
    logic [CW-1:0]      flds
  );
    lpt_pkg::res_t r;
    r.token_kind  = kind;
    r.pair_index  = IW'(idx);
    r.span_start  = SSW'(start);
    r.span_length = SLW'(len);
    r.parse_ok    = ok;
    r.tag_total   = tags;
    r.field_total = flds;
    r.last_result = 1'b0;
    return r;
  endfunction

  lpt_pkg::phase_e ph_q, ph_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   tok_q, tok_d;
  logic [PW-1:0]   sne_q, sne_d;
  logic            esc_q, esc_d;
  logic            skip_q, skip_d;
  logic [CW-1:0]   tags_q, tags_d;
  logic [CW-1:0]   flds_q, flds_d;

  logic [CW-1:0]   lim_tags, lim_flds;
  logic [7:0]      b;
  logic            eos;
  logic [PW-1:0]   pos_n;
  logic [PW-1:0]   len;
  logic            fin_en;
  logic            fin_dangle;
  logic [PW-1:0]   fin_upto;
  logic            fin_ok;
  logic            tail_en;
  logic            do_reset;
  logic [1:0]      n;
  lpt_pkg::res_t   res_a [2];

  assign lim_tags = (max_tags_i > SlotCap) ? SlotCap : max_tags_i;
  assign lim_flds = (max_fields_i > SlotCap) ? SlotCap : max_fields_i;
  assign b        = item_i.text_byte;
  assign eos      = item_i.end_of_string;
  assign pos_n    = pos_q + PW'(1);
  assign len      = pos_q - tok_q;

  always_comb begin
    ph_d       = ph_q;
    pos_d      = pos_q;
    tok_d      = tok_q;
    sne_d      = sne_q;
    esc_d      = esc_q;
    skip_d     = skip_q;
    tags_d     = tags_q;
    flds_d     = flds_q;
    fin_en     = 1'b0;
    fin_dangle = 1'b0;
    fin_upto   = pos_q;
    fin_ok     = 1'b0;
    tail_en    = 1'b0;
    do_reset   = 1'b0;
    n          = 2'd0;
    res_a[0]   = '0;
    res_a[1]   = '0;

    if (ph_q == lpt_pkg::PH_DRAIN) begin
      do_reset = eos || (b == lpt_pkg::CH_NUL);
    end else if (b == lpt_pkg::CH_NUL) begin
      fin_en     = 1'b1;
      fin_dangle = esc_q;
      fin_upto   = pos_q;
      do_reset   = 1'b1;
    end else if (pos_q >= LineMax) begin
      res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tags_q, flds_q);
      n = n + 2'd1;
      ph_d = lpt_pkg::PH_DRAIN;
      tail_en = 1'b1;
    end else begin
      pos_d   = pos_n;
      tail_en = 1'b1;
      if (esc_q) begin
        esc_d = 1'b0;
        if (ph_q == lpt_pkg::PH_STAMP && b != lpt_pkg::CH_SPACE) begin
          sne_d = pos_n;
        end
      end else if (skip_q && b == lpt_pkg::CH_SPACE) begin
        tok_d = pos_n;
        sne_d = pos_n;
      end else begin
        skip_d = 1'b0;
        if (b == lpt_pkg::CH_BSLASH) begin
          if (eos) begin
            res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tags_q, flds_q);
            n = n + 2'd1;
            ph_d = lpt_pkg::PH_DRAIN;
          end else begin
            esc_d = 1'b1;
            if (ph_q == lpt_pkg::PH_STAMP) begin
              sne_d = pos_n;
            end
          end
        end else begin
          unique case (ph_q)
            lpt_pkg::PH_MEAS: begin
              if (b == lpt_pkg::CH_COMMA || b == lpt_pkg::CH_SPACE) begin
                if (len == '0) begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tags_q, flds_q);
                  n = n + 2'd1;
                  ph_d = lpt_pkg::PH_DRAIN;
                end else begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_MEAS, '0, tok_q, len, 1'b0, '0, '0);
                  n = n + 2'd1;
                  tok_d = pos_n;
                  if (b == lpt_pkg::CH_COMMA) begin
                    ph_d = lpt_pkg::PH_TAGK;
                  end else begin
                    ph_d   = lpt_pkg::PH_FKEY;
                    skip_d = 1'b1;
                  end
                end
              end
            end
            lpt_pkg::PH_TAGK: begin
              if (b == lpt_pkg::CH_EQ) begin
                if (tags_q >= lim_tags || len == '0) begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tags_q, flds_q);
                  n = n + 2'd1;
                  ph_d = lpt_pkg::PH_DRAIN;
                end else begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_TAG_KEY, tags_q, tok_q, len, 1'b0, '0, '0);
                  n = n + 2'd1;
                  tok_d = pos_n;
                  ph_d  = lpt_pkg::PH_TAGV;
                end
              end
            end
            lpt_pkg::PH_TAGV: begin
              if (b == lpt_pkg::CH_COMMA || b == lpt_pkg::CH_SPACE) begin
                if (len == '0) begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tags_q, flds_q);
                  n = n + 2'd1;
                  ph_d = lpt_pkg::PH_DRAIN;
                end else begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_TAG_VAL, tags_q, tok_q, len, 1'b0, '0, '0);
                  n = n + 2'd1;
                  tags_d = tags_q + CW'(1);
                  tok_d  = pos_n;
                  if (b == lpt_pkg::CH_COMMA) begin
                    ph_d = lpt_pkg::PH_TAGK;
                  end else begin
                    ph_d   = lpt_pkg::PH_FKEY;
                    skip_d = 1'b1;
                  end
                end
              end
            end
            lpt_pkg::PH_FKEY: begin
              if (b == lpt_pkg::CH_EQ) begin
                if (flds_q >= lim_flds || len == '0) begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tags_q, flds_q);
                  n = n + 2'd1;
                  ph_d = lpt_pkg::PH_DRAIN;
                end else begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_FIELD_KEY, flds_q, tok_q, len, 1'b0, '0, '0);
                  n = n + 2'd1;
                  tok_d = pos_n;
                  ph_d  = lpt_pkg::PH_FVAL;
                end
              end
            end
            lpt_pkg::PH_FVAL: begin
              if (b == lpt_pkg::CH_COMMA || b == lpt_pkg::CH_SPACE ||
                  b == lpt_pkg::CH_LF || b == lpt_pkg::CH_CR) begin
                if (len == '0) begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b0, tags_q, flds_q);
                  n = n + 2'd1;
                  ph_d = lpt_pkg::PH_DRAIN;
                end else begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_FIELD_VAL, flds_q, tok_q, len, 1'b0, '0, '0);
                  n = n + 2'd1;
                  flds_d = flds_q + CW'(1);
                  tok_d  = pos_n;
                  if (b == lpt_pkg::CH_COMMA) begin
                    ph_d = lpt_pkg::PH_FKEY;
                  end else if (b == lpt_pkg::CH_SPACE) begin
                    ph_d   = lpt_pkg::PH_STAMP;
                    skip_d = 1'b1;
                    sne_d  = pos_n;
                  end else begin
                    res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, 1'b1, tags_q,
                                         flds_d);
                    n = n + 2'd1;
                    ph_d = lpt_pkg::PH_DRAIN;
                  end
                end
              end
            end
            lpt_pkg::PH_STAMP: begin
              if (b == lpt_pkg::CH_LF || b == lpt_pkg::CH_CR) begin
                if (sne_q > tok_q) begin
                  res_a[n[0]] = mk_res(lpt_pkg::KIND_STAMP, '0, tok_q, sne_q - tok_q, 1'b0,
                                       '0, '0);
                  n = n + 2'd1;
                end
                res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, flds_q != '0, tags_q,
                                     flds_q);
                n = n + 2'd1;
                ph_d = lpt_pkg::PH_DRAIN;
              end else if (b != lpt_pkg::CH_SPACE) begin
                sne_d = pos_n;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (tail_en && eos) begin
      do_reset = 1'b1;
      if (ph_d != lpt_pkg::PH_DRAIN) begin
        fin_en   = 1'b1;
        fin_upto = pos_d;
      end
    end

    // The line end reports a pending field value or timestamp, then the status.
    if (fin_en) begin
      if (!fin_dangle && ph_d == lpt_pkg::PH_FVAL) begin
        if (fin_upto > tok_d) begin
          res_a[n[0]] = mk_res(lpt_pkg::KIND_FIELD_VAL, flds_d, tok_d, fin_upto - tok_d, 1'b0,
                               '0, '0);
          n = n + 2'd1;
          flds_d = flds_d + CW'(1);
          fin_ok = 1'b1;
        end
      end else if (!fin_dangle && ph_d == lpt_pkg::PH_STAMP) begin
        if (sne_d > tok_d) begin
          res_a[n[0]] = mk_res(lpt_pkg::KIND_STAMP, '0, tok_d, sne_d - tok_d, 1'b0, '0, '0);
          n = n + 2'd1;
        end
        fin_ok = (flds_d != '0);
      end
      res_a[n[0]] = mk_res(lpt_pkg::KIND_STATUS, '0, '0, '0, fin_ok, tags_d, flds_d);
      n = n + 2'd1;
    end

    if (do_reset) begin
      ph_d   = lpt_pkg::PH_MEAS;
      pos_d  = '0;
      tok_d  = '0;
      sne_d  = '0;
      esc_d  = 1'b0;
      skip_d = 1'b0;
      tags_d = '0;
      flds_d = '0;
    end

    if (n == 2'd1) begin
      res_a[0].last_result = 1'b1;
    end else if (n == 2'd2) begin
      res_a[1].last_result = 1'b1;
    end
  end

  assign step_o.cnt  = n;
  assign step_o.res0 = res_a[0];
  assign step_o.res1 = res_a[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= lpt_pkg::PH_MEAS;
      pos_q  <= '0;
      tok_q  <= '0;
      sne_q  <= '0;
      esc_q  <= 1'b0;
      skip_q <= 1'b0;
      tags_q <= '0;
      flds_q <= '0;
    end else if (fire_i) begin
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      tok_q  <= tok_d;
      sne_q  <= sne_d;
      esc_q  <= esc_d;
      skip_q <= skip_d;
      tags_q <= tags_d;
      flds_q <= flds_d;
    end
  end

`ifndef ASSERT_OFF
  a_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && step_o.cnt == 2'd2) |-> (!step_o.res0.last_result && step_o.res1.last_result))
    else $error("two results in one step must mark only the second as last");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && step_o.cnt == 2'd1) |-> step_o.res0.last_result)
    else $error("a single result must be marked last");

  a_drain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && ph_q == lpt_pkg::PH_DRAIN) |-> (step_o.cnt == 2'd0))
    else $error("a drained line must not produce results");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lpt_out_stage.sv =====
`default_nettype none

module lpt_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lpt_pkg::step_t  step_i,
  input  wire logic            fire_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lpt_pkg::res_t        out_data_o
);

  logic          out_vld_q, out_vld_d;
  logic          sp_vld_q, sp_vld_d;
  lpt_pkg::res_t out_q, out_d;
  lpt_pkg::res_t sp_q, sp_d;
  logic          pop;

  assign pop    = out_vld_q && out_ready_i;
  assign take_o = !sp_vld_q && (!out_vld_q || out_ready_i);

  always_comb begin
    out_vld_d = out_vld_q;
    sp_vld_d  = sp_vld_q;
    out_d     = out_q;
    sp_d      = sp_q;
    priority if (sp_vld_q) begin
      if (pop) begin
        out_d    = sp_q;
        sp_vld_d = 1'b0;
      end
    end else if (fire_i) begin
      out_vld_d = (step_i.cnt != 2'd0);
      out_d     = step_i.res0;
      sp_vld_d  = (step_i.cnt == 2'd2);
      sp_d      = step_i.res1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sp_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      sp_vld_q  <= sp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sp_q  <= sp_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_spill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_vld_q |-> out_vld_q)
    else $error("spill beat held while the output register is empty");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.token_kind == lpt_pkg::KIND_STATUS) |-> out_q.last_result)
    else $error("a status beat must close its step");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/line_protocol_tokenizer.sv =====
// Line-protocol tokenizer. One text byte per input beat on in_*: text_byte and
// end_of_string. Each beat yields zero, one or two result beats on out_*: token
// spans (kind, pair index, start offset, length) and, at the end of a line
// or at the first error, one status beat with the pass flag and the tag and field counts.
// last_result marks the final result beat that belongs to one input beat.
// The cfg_* port writes max_tags (index 0) or max_fields (index 1), one per
// write; write them only while no beat is in flight.
// A byte accepted on in_* waits in the input register and is parsed once the
// output stage can take its results, its first result entering the output
// register. Throughput is one byte per cycle while the receiver keeps up and
// no byte yields two results; the single output port makes a byte with two
// results hold back the next until its second moves from spill to output.
// A two-beat output stage (output register plus spill register) and the
// input register let the block take a new byte while a result waits.
// When the receiver stalls, results are held stable, the input register (and
// the spill register, after a two-result byte) fills, and in_ready_o drops.
// Reset empties all registers, starts a fresh line and sets both limits to five.
`default_nettype none

module line_protocol_tokenizer #(
  parameter int unsigned LINE_BYTES = lpt_pkg::LINE_BYTES_DEF,
  parameter int unsigned PAIR_SLOTS = lpt_pkg::PAIR_SLOTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lpt_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lpt_pkg::res_t                        out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lpt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lpt_pkg::CFG_W-1:0]       cfg_wdata_i
);

  logic                      in_vld_q;
  lpt_pkg::in_t              in_q;
  logic [lpt_pkg::CNT_W-1:0] max_tags_q;
  logic [lpt_pkg::CNT_W-1:0] max_fields_q;
  logic                      take;
  logic                      fire;
  lpt_pkg::step_t            step;

  assign fire       = in_vld_q && take;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tags_q   <= lpt_pkg::CFG_RESET_VAL;
      max_fields_q <= lpt_pkg::CFG_RESET_VAL;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lpt_pkg::CFG_MAX_TAGS) begin
        max_tags_q <= cfg_wdata_i;
      end else begin
        max_fields_q <= cfg_wdata_i;
      end
    end
  end

  lpt_core #(
    .LINE_BYTES (LINE_BYTES),
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_q),
    .max_tags_i   (max_tags_q),
    .max_fields_i (max_fields_q),
    .step_o       (step)
  );

  lpt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .fire_i      (fire),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
